// ===== sv/dagen_pkg.sv =====
// Shared types, widths and helpers for the anchor box generator.
`timescale 1ns / 1ps

package dagen_pkg;

   // Table geometry
   localparam int MAX_RATIOS = 4;
   localparam int MAX_SIZES  = 4;
   localparam int IDX_W      = 2;
   localparam int SLOT_W     = 2 * IDX_W;
   localparam int SLOTS      = MAX_RATIOS * MAX_SIZES;

   // Register and field widths
   localparam int STEP_PX_W = 11;
   localparam int OFF_W     = 9;
   localparam int CNT_W     = 3;
   localparam int ENTRY_W   = 16;
   localparam int TABLE_W   = 64;
   localparam int COORD_W   = 12;
   localparam int EDGE_W    = 28;
   localparam int CSR_IDX_W = 3;

   // Set-up arithmetic widths
   localparam int NUM_W    = 44;
   localparam int REM_W    = ENTRY_W + 1;
   localparam int SQ_N_W   = 40;
   localparam int ROOT_W   = 20;
   localparam int SQ_REM_W = ROOT_W + 2;
   localparam int BW_W     = 20;
   localparam int BH_W     = 24;
   localparam int STEP_W   = 6;

   // Box pipeline widths
   localparam int PROD_W  = COORD_W + STEP_PX_W;
   localparam int OPROD_W = OFF_W + STEP_PX_W - 1;
   localparam int A_W     = 32;
   localparam int C_W     = 50;
   localparam int K_W     = C_W - 4;
   localparam int T_W     = 18;

   localparam logic [STEP_PX_W-1:0] STRIDE_MAX = STEP_PX_W'(1024);
   localparam logic [OFF_W-1:0]     OFF_MAX    = OFF_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIDE_X       = 3'd0,
      CSR_STRIDE_Y       = 3'd1,
      CSR_CENTER_OFFSET  = 3'd2,
      CSR_RATIO_COUNT    = 3'd3,
      CSR_SIZE_COUNT     = 3'd4,
      CSR_RATIO_TABLE    = 3'd5,
      CSR_SIZE_TABLE     = 3'd6,
      CSR_VARIANCE_TABLE = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      PREP_AREA,
      PREP_DIV_AREA,
      PREP_ROOT_LOAD,
      PREP_ROOT,
      PREP_WIDTH,
      PREP_HEIGHT,
      PREP_X_LOAD,
      PREP_X_DIV,
      PREP_X_SAVE,
      PREP_Y_LOAD,
      PREP_Y_DIV,
      PREP_Y_SAVE,
      PREP_DONE
   } prep_state_type;

   typedef struct packed {
      logic [COORD_W-1:0] cell_column;
      logic [COORD_W-1:0] cell_row;
   } req_type;

   typedef struct packed {
      logic signed [EDGE_W-1:0] box_x_min;
      logic signed [EDGE_W-1:0] box_y_min;
      logic signed [EDGE_W-1:0] box_x_max;
      logic signed [EDGE_W-1:0] box_y_max;
      logic [ENTRY_W-1:0]       variance_0;
      logic [ENTRY_W-1:0]       variance_1;
      logic [ENTRY_W-1:0]       variance_2;
      logic [ENTRY_W-1:0]       variance_3;
      logic [IDX_W-1:0]         ratio_index;
      logic [IDX_W-1:0]         size_index;
      logic                     last_box;
   } rsp_type;

   // Clamped configuration as seen by the datapath
   typedef struct packed {
      logic [STEP_PX_W-1:0] stride_x;
      logic [STEP_PX_W-1:0] stride_y;
      logic [OFF_W-1:0]     center_offset;
      logic [CNT_W-1:0]     ratio_count;
      logic [CNT_W-1:0]     size_count;
      logic [TABLE_W-1:0]   ratio_table;
      logic [TABLE_W-1:0]   size_table;
      logic [TABLE_W-1:0]   variance_table;
   } cfg_type;

   // Per ratio/size half-extent terms: 8*size*base = quot*stride + rem
   typedef struct packed {
      logic [NUM_W-1:0]     quot_x;
      logic [STEP_PX_W-1:0] rem_x;
      logic [NUM_W-1:0]     quot_y;
      logic [STEP_PX_W-1:0] rem_y;
   } slot_type;

   function automatic logic [ENTRY_W-1:0] entry16(input logic [TABLE_W-1:0] tbl,
                                                  input logic [IDX_W-1:0] idx);
      entry16 = tbl[idx*ENTRY_W +: ENTRY_W];
   endfunction

endpackage

// ===== sv/detection_anchor_box_generator_core.sv =====
// Anchor box generator top level: request expander, set-up and box pipeline.
`timescale 1ns / 1ps

// Each accepted request (one feature-map cell) expands into ratio_count *
// size_count boxes, ratio outer and size inner, issued one box per clock,
// while the pipeline is not stalled, into a four-stage pipeline; the next
// request is taken in the cycle its predecessor issues its last box. The
// pipeline stalls as a whole on rsp_ready. After reset, and after every
// configuration write, a set-up sequencer with one shared bit-serial
// divider and square-root unit rebuilds the per-ratio, per-size terms;
// req_ready stays low until it has finished.

module detection_anchor_box_generator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  dagen_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dagen_pkg::rsp_type             rsp_data,
   input  logic                           csr_write_enable,
   input  logic [dagen_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dagen_pkg::TABLE_W-1:0]  csr_wdata
);
   import dagen_pkg::*;

   cfg_type  cfg;
   slot_type slot_data;
   logic [SLOT_W-1:0] slot_addr;
   logic prep_ready, advance;

   req_type cell_ff;
   logic    busy_ff;
   logic [IDX_W-1:0] r_ff, s_ff;
   logic [IDX_W-1:0] r_last, s_last;
   logic last_now, accept;

   dagen_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   dagen_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write_enable),
      .cfg        (cfg),
      .slot_addr  (slot_addr),
      .slot_data  (slot_data),
      .prep_ready (prep_ready)
   );

   // Final ratio and size index of the run
   assign r_last   = IDX_W'(cfg.ratio_count - CNT_W'(1));
   assign s_last   = IDX_W'(cfg.size_count - CNT_W'(1));
   assign last_now = (r_ff == r_last) && (s_ff == s_last);

   // Once set-up is done and no register is being written, take a new request when idle or while issuing the last box
   assign req_ready = prep_ready && !csr_write_enable && (!busy_ff || (advance && last_now));
   assign accept    = req_valid && req_ready;

   // Expander control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         r_ff    <= '0;
         s_ff    <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         r_ff    <= '0;
         s_ff    <= '0;
      end else if (busy_ff && advance) begin
         if (last_now) begin
            busy_ff <= 1'b0;
         end else if (s_ff == s_last) begin
            s_ff <= '0;
            r_ff <= r_ff + IDX_W'(1);
         end else begin
            s_ff <= s_ff + IDX_W'(1);
         end
      end
   end

   // Hold the cell while its boxes issue
   always_ff @(posedge clock) begin
      if (accept) cell_ff <= req_data;
   end

   dagen_box u_box (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (busy_ff),
      .in_cell      (cell_ff),
      .in_ratio_idx (r_ff),
      .in_size_idx  (s_ff),
      .in_last      (last_now),
      .slot_addr    (slot_addr),
      .slot_data    (slot_data),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== sv/dagen_csr.sv =====
// Configuration registers and their range clamps.
`timescale 1ns / 1ps

module dagen_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [dagen_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dagen_pkg::TABLE_W-1:0]  csr_wdata,
   output dagen_pkg::cfg_type             cfg
);
   import dagen_pkg::*;

   logic [STEP_PX_W-1:0] stride_x_ff, stride_y_ff;
   logic [OFF_W-1:0]     offset_ff;
   logic [CNT_W-1:0]     ratio_count_ff, size_count_ff;
   logic [TABLE_W-1:0]   ratio_table_ff, size_table_ff, variance_table_ff;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_x_ff       <= STEP_PX_W'(16);
         stride_y_ff       <= STEP_PX_W'(16);
         offset_ff         <= OFF_W'(128);
         ratio_count_ff    <= CNT_W'(1);
         size_count_ff     <= CNT_W'(1);
         ratio_table_ff    <= TABLE_W'(4096);
         size_table_ff     <= TABLE_W'(64);
         variance_table_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STRIDE_X:       stride_x_ff       <= csr_wdata[STEP_PX_W-1:0];
            CSR_STRIDE_Y:       stride_y_ff       <= csr_wdata[STEP_PX_W-1:0];
            CSR_CENTER_OFFSET:  offset_ff         <= csr_wdata[OFF_W-1:0];
            CSR_RATIO_COUNT:    ratio_count_ff    <= csr_wdata[CNT_W-1:0];
            CSR_SIZE_COUNT:     size_count_ff     <= csr_wdata[CNT_W-1:0];
            CSR_RATIO_TABLE:    ratio_table_ff    <= csr_wdata;
            CSR_SIZE_TABLE:     size_table_ff     <= csr_wdata;
            CSR_VARIANCE_TABLE: variance_table_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp strides, offset and counts into their legal ranges
   always_comb begin
      cfg.stride_x = (stride_x_ff == '0) ? STEP_PX_W'(1) :
                     (stride_x_ff > STRIDE_MAX) ? STRIDE_MAX : stride_x_ff;
      cfg.stride_y = (stride_y_ff == '0) ? STEP_PX_W'(1) :
                     (stride_y_ff > STRIDE_MAX) ? STRIDE_MAX : stride_y_ff;
      cfg.center_offset = (offset_ff > OFF_MAX) ? OFF_MAX : offset_ff;
      cfg.ratio_count = (ratio_count_ff == '0) ? CNT_W'(1) :
                        (ratio_count_ff > CNT_W'(MAX_RATIOS)) ? CNT_W'(MAX_RATIOS) :
                        ratio_count_ff;
      cfg.size_count  = (size_count_ff == '0) ? CNT_W'(1) :
                        (size_count_ff > CNT_W'(MAX_SIZES)) ? CNT_W'(MAX_SIZES) :
                        size_count_ff;
      cfg.ratio_table    = ratio_table_ff;
      cfg.size_table     = size_table_ff;
      cfg.variance_table = variance_table_ff;
   end

endmodule

// ===== sv/dagen_prep.sv =====
// Set-up sequencer: base sizes per ratio and half-extent quotients per slot.
`timescale 1ns / 1ps

module dagen_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  dagen_pkg::cfg_type            cfg,
   input  logic [dagen_pkg::SLOT_W-1:0]  slot_addr,
   output dagen_pkg::slot_type           slot_data,
   output logic                          prep_ready
);
   import dagen_pkg::*;

   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(NUM_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

   prep_state_type state_ff, state_in;
   logic [IDX_W-1:0]    r_ff, r_in, s_ff, s_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [ENTRY_W-1:0]  den_ff, den_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [SQ_N_W-1:0]   sqn_ff, sqn_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SQ_REM_W-1:0] sqrem_ff, sqrem_in;
   logic [BW_W-1:0]     bw_ff, bw_in;
   logic [BH_W-1:0]     bh_ff, bh_in;

   logic [NUM_W-1:0]     qx_ff [SLOTS];
   logic [STEP_PX_W-1:0] rx_ff [SLOTS];
   logic [NUM_W-1:0]     qy_ff [SLOTS];
   logic [STEP_PX_W-1:0] ry_ff [SLOTS];

   logic [ENTRY_W-1:0]  ratio, size;
   logic [REM_W-1:0]    div_sh, div_rem;
   logic                div_ge;
   logic [SQ_REM_W-1:0] sq_sh, sq_trial;
   logic                sq_ge;
   logic [SLOT_W-1:0]   wr_slot;

   assign ratio   = (entry16(cfg.ratio_table, r_ff) == '0) ? ENTRY_W'(1) :
                    entry16(cfg.ratio_table, r_ff);
   assign size    = entry16(cfg.size_table, s_ff);
   assign wr_slot = {r_ff, s_ff};

   // One restoring division step
   assign div_sh  = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign div_ge  = (div_sh >= {1'b0, den_ff});
   assign div_rem = div_ge ? (div_sh - {1'b0, den_ff}) : div_sh;

   // One square root digit step
   assign sq_sh    = {sqrem_ff[SQ_REM_W-3:0], sqn_ff[SQ_N_W-1 -: 2]};
   assign sq_trial = {root_ff, 2'b01};
   assign sq_ge    = (sq_sh >= sq_trial);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PREP_AREA:      state_in = PREP_DIV_AREA;
         PREP_DIV_AREA:  if (step_ff == DIV_LAST) state_in = PREP_ROOT_LOAD;
         PREP_ROOT_LOAD: state_in = PREP_ROOT;
         PREP_ROOT:      if (step_ff == ROOT_LAST) state_in = PREP_WIDTH;
         PREP_WIDTH:     state_in = PREP_HEIGHT;
         PREP_HEIGHT:    state_in = PREP_X_LOAD;
         PREP_X_LOAD:    state_in = PREP_X_DIV;
         PREP_X_DIV:     if (step_ff == DIV_LAST) state_in = PREP_X_SAVE;
         PREP_X_SAVE:    state_in = PREP_Y_LOAD;
         PREP_Y_LOAD:    state_in = PREP_Y_DIV;
         PREP_Y_DIV:     if (step_ff == DIV_LAST) state_in = PREP_Y_SAVE;
         PREP_Y_SAVE: begin
            if (s_ff != IDX_W'(MAX_SIZES - 1)) state_in = PREP_X_LOAD;
            else if (r_ff != IDX_W'(MAX_RATIOS - 1)) state_in = PREP_AREA;
            else state_in = PREP_DONE;
         end
         PREP_DONE:      state_in = PREP_DONE;
         default:        state_in = PREP_AREA;
      endcase
      if (restart) state_in = PREP_AREA;
   end

   // Outputs
   always_comb begin
      prep_ready = (state_ff == PREP_DONE);
   end

   // Datapath next values
   always_comb begin
      r_in     = r_ff;
      s_in     = s_ff;
      step_in  = step_ff + STEP_W'(1);
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      sqn_in   = sqn_ff;
      root_in  = root_ff;
      sqrem_in = sqrem_ff;
      bw_in    = bw_ff;
      bh_in    = bh_ff;
      case (state_ff)
         PREP_AREA: begin
            num_in  = (NUM_W'(cfg.stride_x) * NUM_W'(cfg.stride_y)) << 14;
            den_in  = ratio;
            rem_in  = '0;
            step_in = '0;
         end
         PREP_DIV_AREA, PREP_X_DIV, PREP_Y_DIV: begin
            num_in = {num_ff[NUM_W-2:0], div_ge};
            rem_in = div_rem;
         end
         PREP_ROOT_LOAD: begin
            sqn_in   = num_ff[SQ_N_W-1:0];
            root_in  = '0;
            sqrem_in = '0;
            step_in  = '0;
         end
         PREP_ROOT: begin
            sqn_in   = {sqn_ff[SQ_N_W-3:0], 2'b00};
            sqrem_in = sq_ge ? (sq_sh - sq_trial) : sq_sh;
            root_in  = {root_ff[ROOT_W-2:0], sq_ge};
         end
         PREP_WIDTH: bw_in = BW_W'(({1'b0, root_ff} + (ROOT_W + 1)'(1)) >> 1);
         PREP_HEIGHT: bh_in = BH_W'(((BW_W + ENTRY_W + 1)'(bw_ff) *
                                     (BW_W + ENTRY_W + 1)'(ratio) +
                                     (BW_W + ENTRY_W + 1)'(2048)) >> 12);
         PREP_X_LOAD: begin
            num_in  = (NUM_W'(size) * NUM_W'(bw_ff)) << 3;
            den_in  = ENTRY_W'(cfg.stride_x);
            rem_in  = '0;
            step_in = '0;
         end
         PREP_Y_LOAD: begin
            num_in  = (NUM_W'(size) * NUM_W'(bh_ff)) << 3;
            den_in  = ENTRY_W'(cfg.stride_y);
            rem_in  = '0;
            step_in = '0;
         end
         PREP_Y_SAVE: begin
            s_in = s_ff + IDX_W'(1);
            if (s_ff == IDX_W'(MAX_SIZES - 1)) r_in = r_ff + IDX_W'(1);
         end
         default: ;
      endcase
      if (restart) begin
         r_in = '0;
         s_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PREP_AREA;
         r_ff     <= '0;
         s_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         s_ff     <= s_in;
         step_ff  <= step_in;
      end
   end

   // Arithmetic registers
   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      sqn_ff   <= sqn_in;
      root_ff  <= root_in;
      sqrem_ff <= sqrem_in;
      bw_ff    <= bw_in;
      bh_ff    <= bh_in;
   end

   // Store quotient and remainder per slot
   always_ff @(posedge clock) begin
      if (state_ff == PREP_X_SAVE) begin
         qx_ff[wr_slot] <= num_ff;
         rx_ff[wr_slot] <= rem_ff[STEP_PX_W-1:0];
      end
      if (state_ff == PREP_Y_SAVE) begin
         qy_ff[wr_slot] <= num_ff;
         ry_ff[wr_slot] <= rem_ff[STEP_PX_W-1:0];
      end
   end

   assign slot_data.quot_x = qx_ff[slot_addr];
   assign slot_data.rem_x  = rx_ff[slot_addr];
   assign slot_data.quot_y = qy_ff[slot_addr];
   assign slot_data.rem_y  = ry_ff[slot_addr];

endmodule

// ===== sv/dagen_box.sv =====
// Four-stage box pipeline: centre products, edge numerators, residues, rounding.
`timescale 1ns / 1ps

module dagen_box (
   input  logic                          clock,
   input  logic                          reset,
   input  dagen_pkg::cfg_type            cfg,
   input  logic                          in_valid,
   input  dagen_pkg::req_type            in_cell,
   input  logic [dagen_pkg::IDX_W-1:0]   in_ratio_idx,
   input  logic [dagen_pkg::IDX_W-1:0]   in_size_idx,
   input  logic                          in_last,
   output logic [dagen_pkg::SLOT_W-1:0]  slot_addr,
   input  dagen_pkg::slot_type           slot_data,
   output logic                          advance,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dagen_pkg::rsp_type            rsp_data
);
   import dagen_pkg::*;

   localparam logic signed [K_W+1:0] EDGE_HI = (K_W + 2)'(134217727);
   localparam logic signed [K_W+1:0] EDGE_LO = -(K_W + 2)'(134217728);
   localparam logic signed [C_W-1:0] HALF_PX = C_W'(128);

   // Round k + t/d half away from zero, then saturate
   function automatic logic signed [EDGE_W-1:0] edge_finish(
      input logic signed [K_W-1:0] k,
      input logic signed [T_W-1:0] t,
      input logic signed [T_W-1:0] d);
      logic signed [T_W-1:0] u;
      logic signed [K_W:0]   kj;
      logic signed [K_W+1:0] q;
      logic                  up;
      if (t < 0) begin
         u  = t + d;
         kj = (K_W + 1)'(k) - (K_W + 1)'(1);
      end else if (t >= d) begin
         u  = t - d;
         kj = (K_W + 1)'(k) + (K_W + 1)'(1);
      end else begin
         u  = t;
         kj = (K_W + 1)'(k);
      end
      up = (kj < 0) ? ((u <<< 1) > d) : ((u <<< 1) >= d);
      q  = (K_W + 2)'(kj) + (K_W + 2)'({1'b0, up});
      if (q > EDGE_HI) edge_finish = EDGE_HI[EDGE_W-1:0];
      else if (q < EDGE_LO) edge_finish = EDGE_LO[EDGE_W-1:0];
      else edge_finish = q[EDGE_W-1:0];
   endfunction

   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic [IDX_W-1:0] r1_ff, s1_ff, r2_ff, s2_ff, r3_ff, s3_ff;
   logic last1_ff, last2_ff, last3_ff;

   logic [PROD_W-1:0]    pcx1_ff, pcy1_ff;
   logic [OPROD_W-1:0]   ocx1_ff, ocy1_ff;
   logic [NUM_W-1:0]     qx1_ff, qy1_ff;
   logic [STEP_PX_W-1:0] rx1_ff, ry1_ff, rx2_ff, ry2_ff;

   logic signed [C_W-1:0] cminx2_ff, cmaxx2_ff, cminy2_ff, cmaxy2_ff;
   logic signed [C_W-1:0] cminx_in, cmaxx_in, cminy_in, cmaxy_in;
   logic [A_W-1:0]        ax, ay;
   logic signed [C_W-1:0] qx16, qy16;

   logic signed [K_W-1:0] kminx3_ff, kmaxx3_ff, kminy3_ff, kmaxy3_ff;
   logic signed [T_W-1:0] tminx3_ff, tmaxx3_ff, tminy3_ff, tmaxy3_ff;
   logic signed [T_W-1:0] tminx_in, tmaxx_in, tminy_in, tmaxy_in;
   logic signed [T_W-1:0] dx, dy;

   rsp_type rsp_ff, rsp_in;

   // Move the whole pipe whenever the output slot is free or being taken
   assign advance   = !vld4_ff || rsp_ready;
   assign slot_addr = {in_ratio_idx, in_size_idx};
   assign rsp_valid = vld4_ff;
   assign rsp_data  = rsp_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (advance) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   // Stage 1: centre products and slot terms
   always_ff @(posedge clock) begin
      if (advance) begin
         pcx1_ff  <= in_cell.cell_column * cfg.stride_x;
         pcy1_ff  <= in_cell.cell_row * cfg.stride_y;
         ocx1_ff  <= cfg.center_offset * (cfg.stride_x - STEP_PX_W'(1));
         ocy1_ff  <= cfg.center_offset * (cfg.stride_y - STEP_PX_W'(1));
         qx1_ff   <= slot_data.quot_x;
         rx1_ff   <= slot_data.rem_x;
         qy1_ff   <= slot_data.quot_y;
         ry1_ff   <= slot_data.rem_y;
         r1_ff    <= in_ratio_idx;
         s1_ff    <= in_size_idx;
         last1_ff <= in_last;
      end
   end

   // Stage 2: edge numerators over sixteenths of a pixel times stride
   always_comb begin
      ax   = A_W'({pcx1_ff, 8'b0}) + A_W'(ocx1_ff);
      ay   = A_W'({pcy1_ff, 8'b0}) + A_W'(ocy1_ff);
      qx16 = signed'(C_W'({qx1_ff, 4'b0}));
      qy16 = signed'(C_W'({qy1_ff, 4'b0}));
      cminx_in = signed'(C_W'(ax)) + HALF_PX - qx16;
      cmaxx_in = signed'(C_W'(ax)) - HALF_PX + qx16;
      cminy_in = signed'(C_W'(ay)) + HALF_PX - qy16;
      cmaxy_in = signed'(C_W'(ay)) - HALF_PX + qy16;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cminx2_ff <= cminx_in;
         cmaxx2_ff <= cmaxx_in;
         cminy2_ff <= cminy_in;
         cmaxy2_ff <= cmaxy_in;
         rx2_ff    <= rx1_ff;
         ry2_ff    <= ry1_ff;
         r2_ff     <= r1_ff;
         s2_ff     <= s1_ff;
         last2_ff  <= last1_ff;
      end
   end

   // Stage 3: split into whole sixteenths and a residue over the divisor
   always_comb begin
      tminx_in = signed'(T_W'(cfg.stride_x) * T_W'(cminx2_ff[3:0])) -
                 signed'(T_W'({rx2_ff, 4'b0}));
      tmaxx_in = signed'(T_W'(cfg.stride_x) * T_W'(cmaxx2_ff[3:0])) +
                 signed'(T_W'({rx2_ff, 4'b0}));
      tminy_in = signed'(T_W'(cfg.stride_y) * T_W'(cminy2_ff[3:0])) -
                 signed'(T_W'({ry2_ff, 4'b0}));
      tmaxy_in = signed'(T_W'(cfg.stride_y) * T_W'(cmaxy2_ff[3:0])) +
                 signed'(T_W'({ry2_ff, 4'b0}));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kminx3_ff <= K_W'(cminx2_ff >>> 4);
         kmaxx3_ff <= K_W'(cmaxx2_ff >>> 4);
         kminy3_ff <= K_W'(cminy2_ff >>> 4);
         kmaxy3_ff <= K_W'(cmaxy2_ff >>> 4);
         tminx3_ff <= tminx_in;
         tmaxx3_ff <= tmaxx_in;
         tminy3_ff <= tminy_in;
         tmaxy3_ff <= tmaxy_in;
         r3_ff     <= r2_ff;
         s3_ff     <= s2_ff;
         last3_ff  <= last2_ff;
      end
   end

   // Stage 4: round, saturate and assemble the result
   always_comb begin
      dx = signed'(T_W'({cfg.stride_x, 4'b0}));
      dy = signed'(T_W'({cfg.stride_y, 4'b0}));
      rsp_in.box_x_min   = edge_finish(kminx3_ff, tminx3_ff, dx);
      rsp_in.box_y_min   = edge_finish(kminy3_ff, tminy3_ff, dy);
      rsp_in.box_x_max   = edge_finish(kmaxx3_ff, tmaxx3_ff, dx);
      rsp_in.box_y_max   = edge_finish(kmaxy3_ff, tmaxy3_ff, dy);
      rsp_in.variance_0  = entry16(cfg.variance_table, IDX_W'(0));
      rsp_in.variance_1  = entry16(cfg.variance_table, IDX_W'(1));
      rsp_in.variance_2  = entry16(cfg.variance_table, IDX_W'(2));
      rsp_in.variance_3  = entry16(cfg.variance_table, IDX_W'(3));
      rsp_in.ratio_index = r3_ff;
      rsp_in.size_index  = s3_ff;
      rsp_in.last_box    = last3_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

endmodule
